@@ rtl/core/phw_pkg.sv @@
// ----------------------------------------------------------------------------
// phw_pkg
// shared types and constants for the windowed pixel histogram engine
// ----------------------------------------------------------------------------
package phw_pkg;

	localparam int NUM_BINS    = 256;
	localparam int COUNT_WIDTH = 32;
	localparam int BIN_W       = $clog2(NUM_BINS);
	localparam int BASE_W      = 8;
	localparam int SIZE_W      = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 9;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	// item kinds
	typedef enum logic {
		KIND_COUNT = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_BASE = 1'b0,
		REG_WINDOW_SIZE = 1'b1
	} cfg_reg_t;

	// bin store read request
	typedef struct packed {
		logic             en;
		logic [BIN_W-1:0] addr;
	} phw_rd_req_t;

	// bin store write request
	typedef struct packed {
		logic                   en;
		logic [BIN_W-1:0]       addr;
		logic [COUNT_WIDTH-1:0] data;
	} phw_wr_req_t;

endpackage

@@ rtl/core/phw_bin_store.sv @@
// ----------------------------------------------------------------------------
// phw_bin_store
// bin counter memory with registered read and per-entry valid bits
// ----------------------------------------------------------------------------
module phw_bin_store (
	input  logic                        clk,
	input  logic                        arst_n,
	input  phw_pkg::phw_rd_req_t        rd,
	input  phw_pkg::phw_wr_req_t        wr,
	output logic [phw_pkg::COUNT_WIDTH-1:0] rd_data
);
	import phw_pkg::*;

	logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
	logic [NUM_BINS-1:0]    valid_q;
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic                   rd_valid_q;

	// payload array, no reset
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[rd.addr];
		end
	end

	// entries never written since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_valid_q <= valid_q[rd.addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

@@ rtl/core/pixel_histogram_window.sv @@
// ----------------------------------------------------------------------------
// pixel_histogram_window
// windowed histogram engine for 8-bit gray pixels with read and clear
// ----------------------------------------------------------------------------
// Takes one item per cycle: a count item bumps the bin of its pixel value when
// the value lies in [window_base, window_base + window_size), saturating at
// the counter maximum; a read item returns the bin count (before any clear)
// and optionally zeroes the bin. Each item passes the memory read and then
// the modify/write-back stage, which puts a read result into the output
// register. A back-to-back hit on the same bin is served by forwarding the
// last written count, so repeated pixels keep the full rate. The only stall
// is a read item finding the output register still full. Bins come out of
// reset as zero through per-bin valid bits, so no clearing pass is needed
// and items are taken right after reset. The user must write configuration
// only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module pixel_histogram_window (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [phw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [phw_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [phw_pkg::BIN_W-1:0]      value,
	input  logic                          clear_after_read,
	// result items
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [phw_pkg::BIN_W-1:0]      bin_index,
	output logic [phw_pkg::COUNT_WIDTH-1:0] bin_count
);
	import phw_pkg::*;

	// configuration registers
	logic [BASE_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;

	// stage 1: item waiting on the memory read data
	logic                   s1_valid_q;
	logic                   kind_s1;
	logic [BIN_W-1:0]       value_s1;
	logic                   clr_s1;
	logic                   inwin_s1;
	logic                   fwd_s1;
	logic [COUNT_WIDTH-1:0] last_wr_q;

	// output register
	logic                   out_valid_q;
	logic [BIN_W-1:0]       bin_index_q;
	logic [COUNT_WIDTH-1:0] bin_count_q;

	logic                   accept;
	logic                   s1_is_read;
	logic                   s1_adv;
	logic                   inwin;
	logic [SIZE_W-1:0]      offset;
	logic [COUNT_WIDTH-1:0] rd_data;
	logic [COUNT_WIDTH-1:0] cur_count;
	phw_rd_req_t            rd_req;
	phw_wr_req_t            wr_req;

	// config writes, other indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WINDOW_BASE: base_q <= cfg_wdata[BASE_W-1:0];
				REG_WINDOW_SIZE: size_q <= cfg_wdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// window test on the incoming pixel, unsigned range compare
	assign offset = SIZE_W'(value) - SIZE_W'(base_q);
	assign inwin  = (value >= base_q) && (offset < size_q);

	// stage 1 only holds when a read result has nowhere to go
	assign s1_is_read = s1_valid_q && (kind_s1 == KIND_READ);
	assign s1_adv     = !s1_is_read || !out_valid_q || out_ready;
	assign in_ready   = s1_adv;
	assign accept     = in_valid && in_ready;

	// memory read issued at accept
	assign rd_req.en   = accept;
	assign rd_req.addr = value;

	// count seen by stage 1, bypassing the write that just landed
	assign cur_count = fwd_s1 ? last_wr_q : rd_data;

	// write back: saturating increment or clear
	always_comb begin
		wr_req.addr = value_s1;
		wr_req.en   = 1'b0;
		wr_req.data = '0;
		if (s1_valid_q && s1_adv) begin
			if (kind_s1 == KIND_READ) begin
				wr_req.en = clr_s1;
			end else begin
				wr_req.en   = inwin_s1;
				wr_req.data = (cur_count == COUNT_MAX) ? cur_count
					: cur_count + COUNT_WIDTH'(1);
			end
		end
	end

	phw_bin_store u_bin_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd      (rd_req),
		.wr      (wr_req),
		.rd_data (rd_data)
	);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_adv) begin
			s1_valid_q <= accept;
		end
	end

	// stage 1 payload, loaded with each item
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind;
			value_s1 <= value;
			clr_s1   <= clear_after_read;
			inwin_s1 <= inwin;
			// same bin written this cycle: memory read returns stale data
			fwd_s1   <= wr_req.en && (wr_req.addr == value);
		end
		if (wr_req.en) begin
			last_wr_q <= wr_req.data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_is_read && s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_is_read && s1_adv) begin
			bin_index_q <= value_s1;
			bin_count_q <= cur_count;
		end
	end

	assign out_valid = out_valid_q;
	assign bin_index = bin_index_q;
	assign bin_count = bin_count_q;

endmodule

@@ rtl/core/phw_checker.sv @@
// ----------------------------------------------------------------------------
// phw_checker
// port-level checks on the histogram engine, bound to the top level
// ----------------------------------------------------------------------------
module phw_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           kind,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [phw_pkg::BIN_W-1:0]       bin_index,
	input logic [phw_pkg::COUNT_WIDTH-1:0] bin_count
);
	import phw_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bin_index) && $stable(bin_count))
		else $error("result changed while stalled");

	// input only stalls behind a full, blocked output
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a read taken with the output empty shows a result once it has passed stage 1
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (kind == KIND_READ) && !out_valid |=> ##1 out_valid)
		else $error("read result missing");

	// a new result always traces back to a read item that passed stage 1 without a stall
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (kind == KIND_READ), 2))
		else $error("result without a read item");

endmodule

bind pixel_histogram_window phw_checker u_phw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.kind      (kind),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.bin_index (bin_index),
	.bin_count (bin_count)
);

@@ tb/tb_pixel_histogram_window.sv @@
// ----------------------------------------------------------------------------
// tb_pixel_histogram_window
// self-checking bench for the windowed pixel histogram engine
// ----------------------------------------------------------------------------
// A short table of directed items runs first: reads right after reset, bins
// 0 and 255, alternating bit patterns, read with and without clear, and the
// window corners (empty window, window reaching past the top, one-bin
// window at the top). Random phases follow, each under its own window
// setting. Every accepted item runs through a local histogram model. Each
// read queues the bin and count it should return, and results are checked
// in order. Both sides idle in short random bursts. In one phase the result
// side holds off long enough to back the engine up. The last phase has no
// idling at all. Counter saturation needs 2^32 hits on one bin and is out
// of reach in simulation.
// ----------------------------------------------------------------------------
module tb_pixel_histogram_window;
	timeunit 1ns;
	timeprecision 1ps;

	import phw_pkg::*;

	localparam int          RAND_PHASES   = 9;
	localparam int          PHASE_ITEMS   = 160;
	localparam int          DIRECTED_ROWS = 31;
	localparam int unsigned DRAIN_LIMIT   = 2000;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned LONG_HOLD     = 60;

	typedef enum logic {
		ROW_ITEM = 1'b0,
		ROW_CFG  = 1'b1
	} row_op_t;

	// one row of the directed plan: an item or a register write
	typedef struct packed {
		row_op_t                op;
		kind_t                  k;
		logic [BIN_W-1:0]       v;
		logic                   clr;
		logic                   typed;
		logic [COUNT_WIDTH-1:0] cnt;
		cfg_reg_t               idx;
		logic [CFG_DATA_W-1:0]  data;
	} stim_row_t;

	// bin and count that a read item should return
	typedef struct packed {
		logic [BIN_W-1:0]       idx;
		logic [COUNT_WIDTH-1:0] cnt;
	} bin_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   in_valid;
	logic                   in_ready;
	logic                   kind;
	logic [BIN_W-1:0]       value;
	logic                   clear_after_read;
	logic                   out_valid;
	logic                   out_ready;
	logic [BIN_W-1:0]       bin_index;
	logic [COUNT_WIDTH-1:0] bin_count;

	// local histogram model: bins and window registers
	logic [COUNT_WIDTH-1:0] pixel_tally [NUM_BINS];
	logic [BASE_W-1:0]      win_base;
	logic [SIZE_W-1:0]      win_size;

	bin_result_t pending_reads [$];
	int unsigned error_count;

	// idling control: idle_on is shared by both sides, the hold-off state is the result side's
	bit          idle_on;
	int unsigned hold_req;
	int unsigned hold_seen;
	int unsigned recv_stall;

	// directed plan, default window at first
	stim_row_t directed_plan [DIRECTED_ROWS] = '{
		// fresh bins read zero, including a clear on an empty bin
		'{ROW_ITEM, KIND_READ,  8'd0,   1'b0, 1'b1, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd255, 1'b1, 1'b1, 32'd0, REG_WINDOW_BASE, 9'd0},
		// extremes and alternating bit patterns
		'{ROW_ITEM, KIND_COUNT, 8'd255, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_COUNT, 8'd255, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_COUNT, 8'd0,   1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_COUNT, 8'd170, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_COUNT, 8'd85,  1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd255, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd255, 1'b1, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd0,   1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd170, 1'b1, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd85,  1'b1, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		// empty window: nothing is counted
		'{ROW_CFG,  KIND_COUNT, 8'd0,   1'b0, 1'b0, 32'd0, REG_WINDOW_SIZE, 9'd0},
		'{ROW_ITEM, KIND_COUNT, 8'd0,   1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_COUNT, 8'd128, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd0,   1'b1, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd128, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		// oversized window from 200, base data with its unused top bit set
		'{ROW_CFG,  KIND_COUNT, 8'd0,   1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'h1c8},
		'{ROW_CFG,  KIND_COUNT, 8'd0,   1'b0, 1'b0, 32'd0, REG_WINDOW_SIZE, 9'd511},
		'{ROW_ITEM, KIND_COUNT, 8'd199, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_COUNT, 8'd200, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_COUNT, 8'd255, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd199, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd200, 1'b1, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd255, 1'b1, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		// one-bin window at the very top
		'{ROW_CFG,  KIND_COUNT, 8'd0,   1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd255},
		'{ROW_CFG,  KIND_COUNT, 8'd0,   1'b0, 1'b0, 32'd0, REG_WINDOW_SIZE, 9'd1},
		'{ROW_ITEM, KIND_COUNT, 8'd254, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_COUNT, 8'd255, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd255, 1'b1, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0},
		'{ROW_ITEM, KIND_READ,  8'd254, 1'b0, 1'b0, 32'd0, REG_WINDOW_BASE, 9'd0}
	};

	pixel_histogram_window dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.value            (value),
		.clear_after_read (clear_after_read),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.bin_index        (bin_index),
		.bin_count        (bin_count)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop in case the engine hangs
	initial begin
		#1_000_000;
		$display("tb_pixel_histogram_window: errors");
		$finish;
	end

	task automatic flag_error(input string msg);
		error_count++;
		$display("ERROR @%0t: %s", $realtime, msg);
	endtask

	// histogram model for one accepted item
	task automatic tally_pixel_item(input kind_t k, input logic [BIN_W-1:0] v,
		input logic clr, output bit gives, output bin_result_t res);
		int unsigned pix;
		int unsigned lo;
		int unsigned span;
		pix  = 32'(v);
		lo   = 32'(win_base);
		span = 32'(win_size);
		gives = 1'b0;
		res   = '0;
		if (k == KIND_COUNT) begin
			// plain unsigned range, so a window past 255 just stops at the top
			if (pix >= lo && (pix - lo) < span && pix < NUM_BINS) begin
				if (pixel_tally[pix] != COUNT_MAX)
					pixel_tally[pix] = pixel_tally[pix] + COUNT_WIDTH'(1);
			end
		end else begin
			gives   = 1'b1;
			res.idx = v;
			res.cnt = pixel_tally[pix];
			if (clr)
				pixel_tally[pix] = '0;
		end
	endtask

	// present one item and hold it until the engine takes it
	task automatic offer_pixel_item(input kind_t k, input logic [BIN_W-1:0] v,
		input logic clr, input bit typed, input logic [COUNT_WIDTH-1:0] typed_cnt);
		bit          gives;
		bin_result_t res;
		int unsigned gap;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 5);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid         = 1'b1;
		kind             = k;
		value            = v;
		clear_after_read = clr;
		do
			@(posedge clk);
		while (!in_ready);
		tally_pixel_item(k, v, clr, gives, res);
		if (gives) begin
			// hand-typed counts stand in for the model on the plainest rows
			if (typed)
				res.cnt = typed_cnt;
			pending_reads.push_back(res);
		end
	endtask

	// drop valid, wait for the outstanding reads, then let in-flight counts land
	task automatic wait_results_drained();
		int unsigned waited;
		@(negedge clk);
		in_valid = 1'b0;
		waited = 0;
		while (pending_reads.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_window_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_WINDOW_BASE)
			win_base = data[BASE_W-1:0];
		else
			win_size = data[SIZE_W-1:0];
	endtask

	// one random phase under a fresh window setting
	task automatic run_window_phase(input logic [BASE_W-1:0] base,
		input logic [SIZE_W-1:0] size, input bit long_hold);
		logic [BIN_W-1:0] hot_vals [6];
		logic [BIN_W-1:0] pix;
		logic [BIN_W-1:0] last_pix;
		int unsigned      top;
		int unsigned      pick;
		kind_t            k;
		logic             clr;
		wait_results_drained();
		write_window_reg(REG_WINDOW_BASE, {1'($urandom_range(0, 1)), base});
		write_window_reg(REG_WINDOW_SIZE, size);
		// six hot bins: the window edges, their outer neighbours and two random picks, so counts pile up
		top = int'(base) + int'(size) - 1;
		if (top > 255)
			top = 255;
		hot_vals[0] = base;
		hot_vals[1] = top[BIN_W-1:0];
		hot_vals[2] = base - BIN_W'(1);
		hot_vals[3] = BIN_W'($urandom_range(0, 255));
		hot_vals[4] = BIN_W'($urandom_range(0, 255));
		hot_vals[5] = top[BIN_W-1:0] + BIN_W'(1);
		last_pix = base;
		if (long_hold)
			hold_req++;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 2)
				pix = last_pix;
			else if (pick < 6)
				pix = hot_vals[$urandom_range(0, 5)];
			else
				pix = BIN_W'($urandom_range(0, 255));
			k   = ($urandom_range(0, 99) < 65) ? KIND_COUNT : KIND_READ;
			clr = ($urandom_range(0, 9) < 3);
			offer_pixel_item(k, pix, clr, 1'b0, '0);
			last_pix = pix;
		end
	endtask

	// result side: random short stalls, one long hold-off on request
	initial begin
		out_ready  = 1'b0;
		recv_stall = 0;
		hold_seen  = 0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_req) begin
				hold_seen  = hold_req;
				recv_stall = LONG_HOLD;
			end else if (recv_stall == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				recv_stall = $urandom_range(1, 5);
			end
			if (recv_stall > 0) begin
				out_ready = 1'b0;
				recv_stall--;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// compare every taken result with the oldest queued read
	always @(posedge clk) begin : check_results
		bin_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_reads.size() == 0) begin
				flag_error($sformatf("result with no read pending: bin %0d count %0d",
					bin_index, bin_count));
			end else begin
				want = pending_reads.pop_front();
				if (bin_index !== want.idx)
					flag_error($sformatf("bin_index %0d, expected %0d", bin_index, want.idx));
				if (bin_count !== want.cnt)
					flag_error($sformatf("bin %0d: bin_count %0d, expected %0d",
						want.idx, bin_count, want.cnt));
			end
		end
	end

	initial begin
		// every input known from time zero
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = REG_WINDOW_BASE;
		cfg_wdata        = '0;
		in_valid         = 1'b0;
		kind             = KIND_COUNT;
		value            = '0;
		clear_after_read = 1'b0;
		idle_on          = 1'b1;
		hold_req         = 0;
		error_count      = 0;
		win_base         = '0;
		win_size         = SIZE_RESET;
		for (int b = 0; b < NUM_BINS; b++)
			pixel_tally[b] = '0;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed plan, register writes only once the engine is idle
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (directed_plan[r].op == ROW_CFG) begin
				wait_results_drained();
				write_window_reg(directed_plan[r].idx, directed_plan[r].data);
			end else begin
				offer_pixel_item(directed_plan[r].k, directed_plan[r].v, directed_plan[r].clr,
					directed_plan[r].typed, directed_plan[r].cnt);
			end
		end

		// random phases: default window with a long hold-off, then the corners and two random windows
		run_window_phase(8'd0,   9'd256, 1'b1);
		run_window_phase(8'd255, 9'd1,   1'b0);
		run_window_phase(8'd0,   9'd1,   1'b0);
		run_window_phase(8'd128, 9'd0,   1'b0);
		run_window_phase(8'd17,  9'd300, 1'b0);
		run_window_phase(8'd255, 9'd511, 1'b0);
		run_window_phase(BASE_W'($urandom_range(0, 255)), SIZE_W'($urandom_range(1, 256)), 1'b0);
		run_window_phase(BASE_W'($urandom_range(0, 255)), SIZE_W'($urandom_range(0, 511)), 1'b0);
		// closing phase at full rate on both sides
		idle_on = 1'b0;
		run_window_phase(8'd0, 9'd256, 1'b0);

		wait_results_drained();
		if (pending_reads.size() != 0)
			flag_error($sformatf("%0d reads never returned", pending_reads.size()));
		if (error_count == 0)
			$display("tb_pixel_histogram_window: clean");
		else
			$display("tb_pixel_histogram_window: errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/phw_pkg.sv
rtl/core/phw_bin_store.sv
rtl/core/pixel_histogram_window.sv
rtl/core/phw_checker.sv
tb/tb_pixel_histogram_window.sv
